### rtl/assert_macros.svh
// assertion macros shared by the rtl files
// depends on clk and arst_n being visible at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/spat_pkg.sv
// types and constants for the sorted peer address table
// no dependencies
package spat_pkg;

	localparam int IP_W       = 32;
	localparam int MAC_W      = 48;
	localparam int POS_W      = 6;
	localparam int TOTAL_W    = 7;
	localparam int DEF_DEPTH  = 64;

	localparam logic [IP_W-1:0]  BCAST_IP      = 32'hffff_ffff;
	localparam logic [IP_W-1:0]  LOOP_NET_MASK = 32'hff00_0000;
	localparam logic [IP_W-1:0]  LOOP_NET      = 32'h7f00_0000;
	localparam logic [MAC_W-1:0] MAC_ONES      = '1;

	localparam logic OP_LOOKUP  = 1'b0;
	localparam logic OP_REQUIRE = 1'b1;

	typedef enum logic [1:0] {
		STAT_FOUND     = 2'd0,
		STAT_INSERTED  = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		S_CMP,
		S_SHIFT,
		S_INSERT
	} state_t;

	typedef struct packed {
		logic [IP_W-1:0]  ip;
		logic             known;
		logic [MAC_W-1:0] mac;
	} entry_t;

endpackage

### rtl/sorted_peer_address_table_unit.sv
// sorted peer address table: binary search plus shifting insert over one table memory
// depends on spat_pkg and assert_macros.svh
//
// Usage
//   Input: drive operation and ip with start; the transaction is taken at a clock edge
//   with start high and busy low. operation 0 looks the address up, 1 inserts it when
//   absent. busy stays high while the transaction is worked on.
//   Output: done is high for exactly one cycle with status, position, has_mac, mac and
//   entry_total. The receiver cannot stall; every result must be taken in that cycle.
//   Configuration: cfg_we writes cfg_wdata to own_mac; write only while busy is low.
//   Sequence: the search issues one table read and one compare per probe (S_SRCH, S_CMP),
//   with at most ceil(log2(entries+1)) probes (7 at 64 entries); a miss resolves in S_SRCH.
//   An insert then moves one entry per cycle through the single memory port pair
//   (entries at and above the insert position), then S_INSERT writes the new one.
//   done is registered and rises in the cycle after the last step; the longest
//   transaction is an insert at position 0 of 63 entries.
//   busy falls with done, so the next start can be taken in the cycle done is high.
//   Reset: clears the entry count, own_mac, state, pend and done; the table memory itself
//   is not cleared, only entries below the count are ever read, so no clearing pass.
module sorted_peer_address_table_unit #(
	parameter int TABLE_DEPTH = spat_pkg::DEF_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         operation,
	input  logic [spat_pkg::IP_W-1:0]    ip,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [spat_pkg::POS_W-1:0]   position,
	output logic                         has_mac,
	output logic [spat_pkg::MAC_W-1:0]   mac,
	output logic [spat_pkg::TOTAL_W-1:0] entry_total,
	input  logic                         cfg_we,
	input  logic [spat_pkg::MAC_W-1:0]   cfg_wdata
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	spat_pkg::state_t  state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, k_q, k_d;
	logic [CW-1:0]     mid_c, k_m1;
	logic              op_q, op_d;
	logic [spat_pkg::IP_W-1:0] ip_q, ip_d;
	logic [spat_pkg::MAC_W-1:0] own_mac_q;
	logic              pend_q, pend_d;
	logic [AW-1:0]     waddr_q, waddr_d;

	// table memory
	spat_pkg::entry_t  table_q [TABLE_DEPTH];
	spat_pkg::entry_t  rd_q;
	logic              mem_re, mem_we;
	logic [AW-1:0]     mem_raddr, mem_waddr;
	spat_pkg::entry_t  mem_wdata;

	// result registers
	logic              done_q, done_d;
	spat_pkg::status_t status_q, status_d;
	logic [spat_pkg::POS_W-1:0]   pos_q, pos_d;
	logic              known_q, known_d;
	logic [spat_pkg::MAC_W-1:0]   mac_q, mac_d;
	logic [spat_pkg::TOTAL_W-1:0] total_q, total_d;

	// mac for a new entry
	logic              new_known;
	logic [spat_pkg::MAC_W-1:0] new_mac;

	assign mid_c = lo_q + ((hi_q - lo_q) >> 1);
	assign k_m1  = k_q - CW'(1);

	always_comb begin
		if (ip_q == spat_pkg::BCAST_IP) begin
			new_known = 1'b1;
			new_mac   = spat_pkg::MAC_ONES;
		end else if ((ip_q & spat_pkg::LOOP_NET_MASK) == spat_pkg::LOOP_NET) begin
			new_known = 1'b1;
			new_mac   = own_mac_q;
		end else begin
			new_known = 1'b0;
			new_mac   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= spat_pkg::S_IDLE;
			count_q   <= '0;
			pend_q    <= 1'b0;
			done_q    <= 1'b0;
			own_mac_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_q  <= pend_d;
			done_q  <= done_d;
			if (cfg_we) begin
				own_mac_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		mid_q    <= mid_d;
		k_q      <= k_d;
		op_q     <= op_d;
		ip_q     <= ip_d;
		waddr_q  <= waddr_d;
		status_q <= status_d;
		pos_q    <= pos_d;
		known_q  <= known_d;
		mac_q    <= mac_d;
		total_q  <= total_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_q[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_q <= table_q[mem_raddr];
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		mid_d     = mid_q;
		k_d       = k_q;
		op_d      = op_q;
		ip_d      = ip_q;
		pend_d    = 1'b0;
		waddr_d   = waddr_q;
		done_d    = 1'b0;
		status_d  = status_q;
		pos_d     = pos_q;
		known_d   = known_q;
		mac_d     = mac_q;
		total_d   = total_q;
		mem_re    = 1'b0;
		mem_raddr = mid_c[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = waddr_q;
		mem_wdata = rd_q;

		// a shift read from the previous cycle lands one slot higher
		if (pend_q) begin
			mem_we = 1'b1;
		end

		case (state_q)
			spat_pkg::S_IDLE: begin
				if (start) begin
					op_d    = operation;
					ip_d    = ip;
					lo_d    = '0;
					hi_d    = count_q;
					state_d = spat_pkg::S_SRCH;
				end
			end
			spat_pkg::S_SRCH: begin
				if (lo_q < hi_q) begin
					mid_d   = mid_c;
					mem_re  = 1'b1;
					state_d = spat_pkg::S_CMP;
				end else begin
					// miss, lo_q is the insert position
					pos_d   = '0;
					known_d = 1'b0;
					mac_d   = '0;
					total_d = spat_pkg::TOTAL_W'(count_q);
					if (op_q == spat_pkg::OP_LOOKUP) begin
						status_d = spat_pkg::STAT_NOT_FOUND;
						done_d   = 1'b1;
						state_d  = spat_pkg::S_IDLE;
					end else if (count_q == DEPTH_C) begin
						status_d = spat_pkg::STAT_FULL;
						done_d   = 1'b1;
						state_d  = spat_pkg::S_IDLE;
					end else begin
						mid_d   = lo_q;
						k_d     = count_q;
						state_d = spat_pkg::S_SHIFT;
					end
				end
			end
			spat_pkg::S_CMP: begin
				if (rd_q.ip == ip_q) begin
					status_d = spat_pkg::STAT_FOUND;
					pos_d    = spat_pkg::POS_W'(mid_q);
					known_d  = rd_q.known;
					mac_d    = rd_q.known ? rd_q.mac : '0;
					total_d  = spat_pkg::TOTAL_W'(count_q);
					done_d   = 1'b1;
					state_d  = spat_pkg::S_IDLE;
				end else begin
					if (rd_q.ip < ip_q) begin
						lo_d = mid_q + CW'(1);
					end else begin
						hi_d = mid_q;
					end
					state_d = spat_pkg::S_SRCH;
				end
			end
			spat_pkg::S_SHIFT: begin
				// read k-1 now, write it to k next cycle
				if (k_q > mid_q) begin
					mem_re    = 1'b1;
					mem_raddr = k_m1[AW-1:0];
					pend_d    = 1'b1;
					waddr_d   = k_q[AW-1:0];
					k_d       = k_m1;
				end else begin
					state_d = spat_pkg::S_INSERT;
				end
			end
			spat_pkg::S_INSERT: begin
				mem_we          = 1'b1;
				mem_waddr       = mid_q[AW-1:0];
				mem_wdata.ip    = ip_q;
				mem_wdata.known = new_known;
				mem_wdata.mac   = new_mac;
				count_d         = count_q + CW'(1);
				status_d        = spat_pkg::STAT_INSERTED;
				pos_d           = spat_pkg::POS_W'(mid_q);
				known_d         = new_known;
				mac_d           = new_mac;
				total_d         = spat_pkg::TOTAL_W'(count_q + CW'(1));
				done_d          = 1'b1;
				state_d         = spat_pkg::S_IDLE;
			end
			default: begin
				state_d = spat_pkg::S_IDLE;
			end
		endcase
	end

	assign busy        = (state_q != spat_pkg::S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign position    = pos_q;
	assign has_mac     = known_q;
	assign mac         = mac_q;
	assign entry_total = total_q;

`include "assert_macros.svh"

	`ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted transaction did not raise busy")
	`ASSERT_CLK(a_done_single, done |=> !done, "result strobe held for more than one cycle")
	`ASSERT_ALWAYS(a_count_bound, count_q <= DEPTH_C, "entry count beyond table depth")
	`ASSERT_CLK(a_full_count, (done && status_q == spat_pkg::STAT_FULL) |-> (count_q == DEPTH_C), "table full reported on a table with room")

endmodule
